/* sv/limit_order_book_table_top_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the order book table
// Shared concurrent check wrappers, clocked on clk_i and idle in reset.
// ---------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_TABLE_TOP_DEFINES_SVH
`define LIMIT_ORDER_BOOK_TABLE_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define LOB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("order book check failed");

// Check a consequence in the cycle after its trigger
`define LOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("order book check failed");

`endif

/* sv/lob_pkg.sv */
// ---------------------------------------------------------------------------
// Order book table package
// Sizes, codes, the slot record and the controller/datapath bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lob_pkg;

  localparam int MAX_ORDERS = 256;
  localparam int NUM_LEVELS = 4096;
  localparam int SLOT_W     = $clog2(MAX_ORDERS);
  localparam int LEVEL_W    = $clog2(NUM_LEVELS);
  localparam int ID_W       = 64;
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 8;
  localparam int SEQ_W      = 40;
  localparam int DCNT_W     = $clog2(PRICE_W + 1);
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_MODIFY  = 3'd1,
    REQ_DELETE  = 3'd2,
    REQ_EXECUTE = 3'd3,
    REQ_TRADE   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_SIDE      = 3'd4,
    ST_OVERFILL  = 3'd5,
    ST_ZERO      = 3'd6,
    ST_NO_MATCH  = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PRICE  = 2'd0,
    CFG_MAX_PRICE  = 2'd1,
    CFG_PRICE_STEP = 2'd2
  } cfg_idx_e;

  localparam logic SIDE_BUY = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [LEVEL_W-1:0] level;
    logic [QTY_W-1:0]   size;
    logic               side;
    logic [SEQ_W-1:0]   seq;
  } rec_t;

  typedef struct packed {
    logic latch;
    logic div_en;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

/* sv/lob_if.sv */
// ---------------------------------------------------------------------------
// Order book channel interfaces
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lob_req_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  req_type;
  logic [lob_pkg::ID_W-1:0]    ord_id;
  logic [lob_pkg::PRICE_W-1:0] price;
  logic [lob_pkg::QTY_W-1:0]   qty;
  logic                        side;

  modport source (output valid, req_type, ord_id, price, qty, side, input ready);
  modport sink (input valid, req_type, ord_id, price, qty, side, output ready);
endinterface

interface lob_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [lob_pkg::ID_W-1:0]  hit_id;
  logic [lob_pkg::QTY_W-1:0] remaining_qty;
  logic                      removed;

  modport source (output valid, status, hit_id, remaining_qty, removed, input ready);
  modport sink (input valid, status, hit_id, remaining_qty, removed, output ready);
endinterface

interface lob_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lob_pkg::CFG_IDX_W-1:0] index;
  logic [lob_pkg::PRICE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/limit_order_book_table_top.sv */
// A request occupies the block from one taken word to the next: an accept
// cycle, the bit-serial level divider (32 quotient bits, then a done check),
// the slot scan (one slot a cycle through the slot memory's single read port,
// with a registered read and a done check) and a commit cycle. Results leave
// through an output register, so a new request can enter while the previous
// word waits to be taken; its commit waits until that word is gone.
// Configuration writes are taken at any time and must only occur while
// idle.
// ---------------------------------------------------------------------------
// Order book table top level
// Resting order table with add, modify, delete, execute and trade requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module limit_order_book_table_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  lob_req_if.sink   req_i,
  lob_rsp_if.source rsp_o,
  lob_cfg_if.sink   cfg_i
);

  lob_pkg::cmd_t cmd;
  lob_pkg::sts_t sts;

  // Sequence the phases of each request
  lob_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the table and compute results
  lob_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_type_i (req_i.req_type),
    .ord_id_i   (req_i.ord_id),
    .price_i    (req_i.price),
    .qty_i      (req_i.qty),
    .side_i     (req_i.side),
    .rsp_o      (rsp_o),
    .cfg_i      (cfg_i)
  );

endmodule

/* sv/lob_ctl.sv */
// ---------------------------------------------------------------------------
// Order book controller
// Sequences one request: level divide, slot scan, commit of the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "limit_order_book_table_top_defines.svh"

module lob_ctl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  lob_pkg::sts_t   sts_i,
  output lob_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Take a word only when no request is in flight
  assign req_ready_o = (state_q == S_IDLE);

  // Decode the commands of the current state
  always_comb begin
    cmd_o         = '0;
    cmd_o.latch   = (state_q == S_IDLE) && req_valid_i;
    cmd_o.div_en  = (state_q == S_DIV);
    cmd_o.scan_en = (state_q == S_SCAN);
    cmd_o.commit  = (state_q == S_COMMIT) && !sts_i.out_busy;
  end

  // Advance through the phases
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_valid_i) state_d = S_DIV;
      S_DIV:    if (sts_i.div_done) state_d = S_SCAN;
      S_SCAN:   if (sts_i.scan_done) state_d = S_COMMIT;
      S_COMMIT: if (!sts_i.out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LOB_ASSERT_NOW(a_commit_needs_free_out, cmd_o.commit, !sts_i.out_busy)
  `LOB_ASSERT_NEXT(a_accept_starts_div, req_valid_i && req_ready_o, cmd_o.div_en)
  `LOB_ASSERT_NEXT(a_commit_returns_idle, cmd_o.commit, req_ready_o && !cmd_o.scan_en)

endmodule

/* sv/lob_dp.sv */
// ---------------------------------------------------------------------------
// Order book datapath
// Registers, slot memory, serial level divider, slot scan and commit logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lob_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lob_pkg::cmd_t               cmd_i,
  output lob_pkg::sts_t               sts_o,
  input  logic [2:0]                  req_type_i,
  input  logic [lob_pkg::ID_W-1:0]    ord_id_i,
  input  logic [lob_pkg::PRICE_W-1:0] price_i,
  input  logic [lob_pkg::QTY_W-1:0]   qty_i,
  input  logic                        side_i,
  lob_rsp_if.source                   rsp_o,
  lob_cfg_if.sink                     cfg_i
);

  localparam int PW = lob_pkg::PRICE_W;
  localparam int SW = lob_pkg::SLOT_W;

  // Configuration registers
  logic [PW-1:0] min_q, max_q, step_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= PW'(4095);
      step_q <= PW'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lob_pkg::CFG_MIN_PRICE:  min_q  <= cfg_i.data;
        lob_pkg::CFG_MAX_PRICE:  max_q  <= cfg_i.data;
        lob_pkg::CFG_PRICE_STEP: step_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Request word, held for the whole request
  logic [2:0]                  type_q;
  logic [lob_pkg::ID_W-1:0]    id_q;
  logic [PW-1:0]               price_q;
  logic [lob_pkg::QTY_W-1:0]   qty_q;
  logic                        side_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      type_q  <= req_type_i;
      id_q    <= ord_id_i;
      price_q <= price_i;
      qty_q   <= qty_i;
      side_q  <= side_i;
    end
  end

  // Restoring divider, one quotient bit a cycle
  logic [PW:0]                   rem_q, rem_d, shift_w;
  logic [PW-1:0]                 quo_q, quo_d, dvs_q;
  logic [lob_pkg::DCNT_W-1:0]    dcnt_q;
  logic                          ge_w;

  assign shift_w = {rem_q[PW-1:0], quo_q[PW-1]};
  assign ge_w    = shift_w >= {1'b0, dvs_q};
  assign rem_d   = ge_w ? (shift_w - {1'b0, dvs_q}) : shift_w;
  assign quo_d   = {quo_q[PW-2:0], ge_w};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      rem_q <= '0;
      quo_q <= price_i - min_q;
      dvs_q <= (step_q == '0) ? PW'(1) : step_q;
    end else if (cmd_i.div_en && (dcnt_q != lob_pkg::DCNT_W'(PW))) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.latch) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_en && (dcnt_q != lob_pkg::DCNT_W'(PW))) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  assign sts_o.div_done = (dcnt_q == lob_pkg::DCNT_W'(PW));

  // Slot memory and valid bits
  lob_pkg::rec_t                 mem [lob_pkg::MAX_ORDERS];
  lob_pkg::rec_t                 rd_q;
  logic [lob_pkg::MAX_ORDERS-1:0] valid_q;
  logic [SW-1:0]                 addr_q, rd_idx_q;
  logic                          issue_q, rd_vld_q;
  logic                          wr_en;
  logic [SW-1:0]                 wr_idx;
  lob_pkg::rec_t                 wr_rec;
  logic                          vset, vclr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (vset) begin
      valid_q[wr_idx] <= 1'b1;
    end else if (vclr) begin
      valid_q[wr_idx] <= 1'b0;
    end
  end

  // Issue one slot address a cycle, compare in the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.latch) begin
      issue_q  <= 1'b1;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      rd_vld_q <= issue_q;
      rd_idx_q <= addr_q;
      if (issue_q) begin
        if (addr_q == SW'(lob_pkg::MAX_ORDERS - 1)) begin
          issue_q <= 1'b0;
        end else begin
          addr_q <= addr_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.scan_done = !issue_q && !rd_vld_q;

  // Track the matched slot and the lowest free slot
  logic          hit_q, free_q;
  logic [SW-1:0] hit_idx_q, free_idx_q;
  lob_pkg::rec_t hit_rec_q;
  logic          cv, id_match, px_ok, elig, better, take;

  always_comb begin
    cv       = valid_q[rd_idx_q];
    id_match = cv && (rd_q.id == id_q);
    px_ok    = (rd_q.side == lob_pkg::SIDE_BUY) ? (price_q >= rd_q.price)
                                                : (price_q <= rd_q.price);
    elig     = cv && (rd_q.size >= qty_q) && px_ok;
    better   = !hit_q || (rd_q.level < hit_rec_q.level) ||
               ((rd_q.level == hit_rec_q.level) && (rd_q.seq < hit_rec_q.seq));
    if (type_q == lob_pkg::REQ_TRADE) begin
      take = rd_vld_q && elig && better;
    end else begin
      take = rd_vld_q && !hit_q && id_match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.latch) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      if (take) hit_q <= 1'b1;
      if (rd_vld_q && !free_q && !cv) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en && take) begin
      hit_idx_q <= rd_idx_q;
      hit_rec_q <= rd_q;
    end
    if (cmd_i.scan_en && rd_vld_q && !free_q && !cv) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // Decide the result and the table update
  logic [lob_pkg::SEQ_W-1:0]  seq_q;
  logic                       seq_inc;
  logic                       range_bad, zero_qty, side_bad;
  logic [lob_pkg::QTY_W-1:0]  left_qty;
  logic [2:0]                 st_d;
  logic [lob_pkg::ID_W-1:0]   oid_d;
  logic [lob_pkg::QTY_W-1:0]  orem_d;
  logic                       orm_d;

  always_comb begin
    range_bad = (price_q < min_q) || (price_q > max_q) ||
                (quo_q >= PW'(lob_pkg::NUM_LEVELS));
    zero_qty  = (qty_q == '0);
    side_bad  = (hit_rec_q.side == lob_pkg::SIDE_BUY) ? (price_q < hit_rec_q.price)
                                                      : (price_q > hit_rec_q.price);
    left_qty  = hit_rec_q.size - qty_q;
    wr_en     = 1'b0;
    wr_idx    = hit_idx_q;
    wr_rec    = hit_rec_q;
    vset      = 1'b0;
    vclr      = 1'b0;
    seq_inc   = 1'b0;
    st_d      = lob_pkg::ST_OK;
    oid_d     = '0;
    orem_d    = '0;
    orm_d     = 1'b0;
    unique case (type_q)
      lob_pkg::REQ_ADD: begin
        if (range_bad) begin
          st_d = lob_pkg::ST_RANGE;
        end else if (zero_qty) begin
          st_d = lob_pkg::ST_ZERO;
        end else if (!hit_q && !free_q) begin
          st_d = lob_pkg::ST_FULL;
        end else begin
          wr_idx  = hit_q ? hit_idx_q : free_idx_q;
          wr_rec  = '{id: id_q, price: price_q, level: quo_q[lob_pkg::LEVEL_W-1:0],
                      size: qty_q, side: side_q, seq: seq_q};
          wr_en   = cmd_i.commit;
          vset    = cmd_i.commit;
          seq_inc = cmd_i.commit;
          oid_d   = id_q;
          orem_d  = qty_q;
        end
      end
      lob_pkg::REQ_MODIFY: begin
        if (!hit_q) begin
          st_d = lob_pkg::ST_NOT_FOUND;
        end else if (range_bad || zero_qty) begin
          st_d   = range_bad ? lob_pkg::ST_RANGE : lob_pkg::ST_ZERO;
          oid_d  = id_q;
          orem_d = hit_rec_q.size;
        end else begin
          wr_rec.price = price_q;
          wr_rec.level = quo_q[lob_pkg::LEVEL_W-1:0];
          wr_rec.size  = qty_q;
          wr_rec.seq   = seq_q;
          wr_en   = cmd_i.commit;
          seq_inc = cmd_i.commit;
          oid_d   = id_q;
          orem_d  = qty_q;
        end
      end
      lob_pkg::REQ_DELETE: begin
        if (!hit_q) begin
          st_d = lob_pkg::ST_NOT_FOUND;
        end else begin
          vclr  = cmd_i.commit;
          oid_d = id_q;
          orm_d = 1'b1;
        end
      end
      lob_pkg::REQ_EXECUTE, lob_pkg::REQ_TRADE: begin
        if ((type_q == lob_pkg::REQ_TRADE) && zero_qty) begin
          st_d = lob_pkg::ST_ZERO;
        end else if (!hit_q) begin
          st_d = (type_q == lob_pkg::REQ_TRADE) ? lob_pkg::ST_NO_MATCH
                                                : lob_pkg::ST_NOT_FOUND;
        end else if ((type_q == lob_pkg::REQ_EXECUTE) && (side_bad ||
                     (qty_q > hit_rec_q.size))) begin
          st_d   = side_bad ? lob_pkg::ST_SIDE : lob_pkg::ST_OVERFILL;
          oid_d  = id_q;
          orem_d = hit_rec_q.size;
        end else begin
          wr_rec.size = left_qty;
          wr_en  = cmd_i.commit;
          vclr   = cmd_i.commit && (left_qty == '0);
          oid_d  = hit_rec_q.id;
          orem_d = left_qty;
          orm_d  = (left_qty == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (seq_inc) begin
      seq_q <= seq_q + 1'b1;
    end
  end

  // Output register, holds a word until taken
  logic                      ovld_q;
  logic [2:0]                ost_q;
  logic [lob_pkg::ID_W-1:0]  oid_q;
  logic [lob_pkg::QTY_W-1:0] orem_q;
  logic                      orm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= cmd_i.commit || (ovld_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ost_q  <= st_d;
      oid_q  <= oid_d;
      orem_q <= orem_d;
      orm_q  <= orm_d;
    end
  end

  assign sts_o.out_busy      = ovld_q && !rsp_o.ready;
  assign rsp_o.valid         = ovld_q;
  assign rsp_o.status        = ost_q;
  assign rsp_o.hit_id        = oid_q;
  assign rsp_o.remaining_qty = orem_q;
  assign rsp_o.removed       = orm_q;

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// Order book table testbench
// Drives add, modify, delete, execute and trade requests through the request
// channel and predicts each response word from a local copy of the table.
// Bursty sender, stalling receiver, several price range settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef bit [lob_pkg::ID_W-1:0]    id_t;
  typedef bit [lob_pkg::PRICE_W-1:0] price_t;
  typedef bit [lob_pkg::QTY_W-1:0]   qty_t;

  typedef struct {
    logic [2:0]                status;
    logic [lob_pkg::ID_W-1:0]  hit_id;
    logic [lob_pkg::QTY_W-1:0] rem;
    logic                      removed;
  } rsp_word_t;

  // Table model and response scoreboard
  class book_scoreboard;
    price_t                       min_px = 0;
    price_t                       max_px = 4095;
    price_t                       step = 1;
    bit                           live [lob_pkg::MAX_ORDERS];
    id_t                          oid [lob_pkg::MAX_ORDERS];
    price_t                       opx [lob_pkg::MAX_ORDERS];
    bit [lob_pkg::LEVEL_W-1:0]    olvl [lob_pkg::MAX_ORDERS];
    qty_t                         osize [lob_pkg::MAX_ORDERS];
    bit                           oside [lob_pkg::MAX_ORDERS];
    bit [lob_pkg::SEQ_W-1:0]      oseq [lob_pkg::MAX_ORDERS];
    bit [lob_pkg::SEQ_W-1:0]      seq_ctr = 0;
    rsp_word_t                    pending_rsp [$];
    int                           errors = 0;

    function void write_reg(lob_pkg::cfg_idx_e idx, price_t val);
      case (idx)
        lob_pkg::CFG_MIN_PRICE:  min_px = val;
        lob_pkg::CFG_MAX_PRICE:  max_px = val;
        lob_pkg::CFG_PRICE_STEP: step = val;
        default: ;
      endcase
    endfunction

    // Price to level; zero when out of range
    function bit price_level(price_t p, output bit [lob_pkg::LEVEL_W-1:0] lvl);
      price_t d;
      price_t q;
      d = (step == 0) ? price_t'(1) : step;
      lvl = 0;
      if (p < min_px || p > max_px) return 0;
      q = (p - min_px) / d;
      if (q >= lob_pkg::NUM_LEVELS) return 0;
      lvl = q[lob_pkg::LEVEL_W-1:0];
      return 1;
    endfunction

    function int find_order(id_t id);
      for (int i = 0; i < lob_pkg::MAX_ORDERS; i++)
        if (live[i] && oid[i] == id) return i;
      return -1;
    endfunction

    function void push(lob_pkg::status_e st, id_t id, qty_t rem, bit rm);
      rsp_word_t w;
      w.status = st;
      w.hit_id = id;
      w.rem = rem;
      w.removed = rm;
      pending_rsp.insert(pending_rsp.size(), w);
    endfunction

    // Apply one accepted request and queue its response word
    function void note_request(bit [2:0] kind, id_t id, price_t p, qty_t qty, bit sd);
      bit [lob_pkg::LEVEL_W-1:0] lvl;
      bit                        in_rng;
      int                        s;
      s = -1;
      in_rng = price_level(p, lvl);
      case (lob_pkg::req_e'(kind))
        lob_pkg::REQ_ADD: begin
          if (!in_rng) push(lob_pkg::ST_RANGE, 0, 0, 0);
          else if (qty == 0) push(lob_pkg::ST_ZERO, 0, 0, 0);
          else begin
            s = find_order(id);
            if (s < 0)
              for (int i = 0; i < lob_pkg::MAX_ORDERS; i++)
                if (!live[i]) begin
                  s = i;
                  break;
                end
            if (s < 0) push(lob_pkg::ST_FULL, 0, 0, 0);
            else begin
              live[s] = 1; oid[s] = id; opx[s] = p; olvl[s] = lvl;
              osize[s] = qty; oside[s] = sd; oseq[s] = seq_ctr++;
              push(lob_pkg::ST_OK, id, qty, 0);
            end
          end
        end
        lob_pkg::REQ_MODIFY, lob_pkg::REQ_DELETE, lob_pkg::REQ_EXECUTE: begin
          s = find_order(id);
          if (s < 0) push(lob_pkg::ST_NOT_FOUND, 0, 0, 0);
          else if (kind == lob_pkg::REQ_MODIFY) begin
            if (!in_rng) push(lob_pkg::ST_RANGE, id, osize[s], 0);
            else if (qty == 0) push(lob_pkg::ST_ZERO, id, osize[s], 0);
            else begin
              opx[s] = p; olvl[s] = lvl; osize[s] = qty; oseq[s] = seq_ctr++;
              push(lob_pkg::ST_OK, id, qty, 0);
            end
          end else if (kind == lob_pkg::REQ_DELETE) begin
            live[s] = 0;
            push(lob_pkg::ST_OK, id, 0, 1);
          end else if ((oside[s] == lob_pkg::SIDE_BUY && p < opx[s]) ||
                       (oside[s] != lob_pkg::SIDE_BUY && p > opx[s])) begin
            push(lob_pkg::ST_SIDE, id, osize[s], 0);
          end else if (qty > osize[s]) begin
            push(lob_pkg::ST_OVERFILL, id, osize[s], 0);
          end else begin
            osize[s] -= qty;
            if (osize[s] == 0) begin
              live[s] = 0;
              push(lob_pkg::ST_OK, id, 0, 1);
            end else push(lob_pkg::ST_OK, id, osize[s], 0);
          end
        end
        lob_pkg::REQ_TRADE: begin
          if (qty == 0) push(lob_pkg::ST_ZERO, 0, 0, 0);
          else begin
            // best level first, then earliest arrival
            for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) begin
              if (!live[i] || osize[i] < qty) continue;
              if (oside[i] == lob_pkg::SIDE_BUY ? p < opx[i] : p > opx[i]) continue;
              if (s < 0 || olvl[i] < olvl[s] || (olvl[i] == olvl[s] && oseq[i] < oseq[s]))
                s = i;
            end
            if (s < 0) push(lob_pkg::ST_NO_MATCH, 0, 0, 0);
            else begin
              osize[s] -= qty;
              if (osize[s] == 0) begin
                live[s] = 0;
                push(lob_pkg::ST_OK, oid[s], 0, 1);
              end else push(lob_pkg::ST_OK, oid[s], osize[s], 0);
            end
          end
        end
        default: push(lob_pkg::ST_OK, 0, 0, 0);
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one response word with the oldest prediction
    task check_response(rsp_word_t got);
      rsp_word_t w;
      if (pending_rsp.size() == 0) begin
        report("response word with nothing outstanding");
        return;
      end
      w = pending_rsp.pop_front();
      if (got.status !== w.status)
        report($sformatf("status got %0d want %0d", got.status, w.status));
      if (got.hit_id !== w.hit_id)
        report($sformatf("hit_id got %h want %h", got.hit_id, w.hit_id));
      if (got.rem !== w.rem)
        report($sformatf("remaining_qty got %0d want %0d", got.rem, w.rem));
      if (got.removed !== w.removed)
        report($sformatf("removed got %0b want %0b", got.removed, w.removed));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  lob_req_if req_if ();
  lob_rsp_if rsp_if ();
  lob_cfg_if cfg_if ();

  limit_order_book_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  book_scoreboard sb = new();

  int  hold_cycles = 0;
  int  burst_left = 0;
  id_t id_pool [48];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: long hold when asked, otherwise a changing stall pattern
  initial begin : rsp_ready_gen
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(100, 2000);
      end
      mode_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_if.ready = 1'b0;
      end else case (mode)
        0: rsp_if.ready = 1'b1;
        1: rsp_if.ready = 1'($urandom_range(0, 1));
        default: rsp_if.ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor both channels at the rising edge
  always @(posedge clk_i) begin
    rsp_word_t w;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      w.status = rsp_if.status;
      w.hit_id = rsp_if.hit_id;
      w.rem = rsp_if.remaining_qty;
      w.removed = rsp_if.removed;
      sb.check_response(w);
    end
    if (rst_ni && req_if.valid && req_if.ready)
      sb.note_request(req_if.req_type, req_if.ord_id, req_if.price, req_if.qty,
                      req_if.side);
  end

  // Offer one request word and hold it until taken
  task automatic send_req(bit [2:0] kind, id_t id, price_t p, qty_t qty, bit sd);
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.req_type = kind;
    req_if.ord_id = id;
    req_if.price = p;
    req_if.qty = qty;
    req_if.side = sd;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic idle_req(int cycles);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Sender pacing: bursts with random gaps
  task automatic pace();
    if (burst_left > 0) burst_left--;
    else begin
      idle_req($urandom_range(0, 320));
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Wait until every predicted word has arrived and the block has settled
  task automatic drain();
    idle_req(0);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(lob_pkg::cfg_idx_e idx, price_t val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_range(price_t lo, price_t hi, price_t st);
    drain();
    write_reg(lob_pkg::CFG_MIN_PRICE, lo);
    write_reg(lob_pkg::CFG_MAX_PRICE, hi);
    write_reg(lob_pkg::CFG_PRICE_STEP, st);
  endtask

  // Mostly in-range prices, now and then any price at all
  function automatic price_t pick_price();
    longint unsigned span;
    longint unsigned d;
    d = (sb.step == 0) ? 1 : sb.step;
    if ($urandom_range(0, 9) == 0 || sb.max_px < sb.min_px) return $urandom();
    span = longint'(sb.max_px) - longint'(sb.min_px);
    if (span > d * 4200) span = d * 4200;
    return sb.min_px + price_t'(({$urandom(), $urandom()} % (span + 1)));
  endfunction

  function automatic qty_t pick_qty();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return qty_t'($urandom());
      default: return qty_t'($urandom_range(1, 20));
    endcase
  endfunction

  // Random requests on the id pool
  task automatic random_reqs(int count);
    int          r;
    bit [2:0]    kind;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) kind = lob_pkg::REQ_ADD;
      else if (r < 50) kind = lob_pkg::REQ_MODIFY;
      else if (r < 60) kind = lob_pkg::REQ_DELETE;
      else if (r < 80) kind = lob_pkg::REQ_EXECUTE;
      else if (r < 97) kind = lob_pkg::REQ_TRADE;
      else kind = 3'($urandom_range(5, 7));
      send_req(kind, ($urandom_range(0, 19) == 0) ? {$urandom(), $urandom()}
                     : id_pool[$urandom_range(0, 47)],
               pick_price(), pick_qty(), 1'($urandom_range(0, 1)));
      pace();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.ord_id = '0;
    req_if.price = '0;
    req_if.qty = '0;
    req_if.side = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lob_pkg::CFG_MIN_PRICE;
    cfg_if.data = '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < 48; i++)
      id_pool[i] = (i < 24) ? id_t'(i) : {$urandom(), $urandom()};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes and each corner of the request rules
    send_req(lob_pkg::REQ_ADD, '0, 0, 255, 1'b0);
    send_req(lob_pkg::REQ_ADD, '1, 4095, 1, 1'b1);
    send_req(lob_pkg::REQ_ADD, 64'd5, 4096, 10, 1'b0);          // above max price
    send_req(lob_pkg::REQ_ADD, 64'd5, 100, 0, 1'b0);            // zero size
    send_req(lob_pkg::REQ_ADD, '0, 200, 50, 1'b0);              // duplicate id replaces
    send_req(lob_pkg::REQ_MODIFY, '0, 32'hFFFF_FFFF, 5, 1'b0);  // out of range
    send_req(lob_pkg::REQ_MODIFY, '0, 150, 0, 1'b0);            // zero size
    send_req(lob_pkg::REQ_MODIFY, '0, 180, 40, 1'b1);
    send_req(lob_pkg::REQ_MODIFY, 64'd77, 180, 40, 1'b0);       // absent
    send_req(lob_pkg::REQ_DELETE, 64'd77, 0, 0, 1'b0);          // absent
    send_req(lob_pkg::REQ_EXECUTE, '0, 179, 1, 1'b0);           // buy below order price
    send_req(lob_pkg::REQ_EXECUTE, '1, 4095, 2, 1'b0);          // overfill
    send_req(lob_pkg::REQ_EXECUTE, '0, 180, 0, 1'b0);           // zero fill no-op
    send_req(lob_pkg::REQ_ADD, 64'd9, 300, 8, 1'b1);
    send_req(lob_pkg::REQ_EXECUTE, 64'd9, 301, 1, 1'b0);        // sell above order price
    send_req(lob_pkg::REQ_EXECUTE, 64'd9, 300, 8, 1'b0);        // exact fill removes
    send_req(lob_pkg::REQ_TRADE, '0, 4095, 0, 1'b0);            // zero size
    send_req(lob_pkg::REQ_TRADE, '0, 0, 200, 1'b0);             // no match
    send_req(lob_pkg::REQ_TRADE, '0, 4095, 15, 1'b1);
    send_req(3'd5, '1, '1, '1, 1'b1);
    send_req(3'd6, '0, 0, 0, 1'b0);
    send_req(3'd7, 64'd3, 7, 7, 1'b1);
    send_req(lob_pkg::REQ_EXECUTE, '1, 4095, 1, 1'b0);          // removes the sell order
    send_req(lob_pkg::REQ_DELETE, '0, 0, 0, 1'b0);

    // Long receiver hold while requests keep coming
    hold_cycles = 3000;
    random_reqs(40);

    // Sender waits out the book, then fills the table to overflow
    drain();
    for (int i = 0; i < 258; i++) begin
      send_req(lob_pkg::REQ_ADD, 64'h1000 + i, price_t'($urandom_range(0, 4095)),
               qty_t'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
      pace();
    end
    for (int i = 0; i < 258; i++) begin
      send_req(lob_pkg::REQ_DELETE, 64'h1000 + i, 0, 0, 1'b0);
      pace();
    end

    random_reqs(320);
    set_range(32'd1000, 32'd13000, 32'd3);
    random_reqs(320);
    set_range(32'd0, 32'hFFFF_FFFF, 32'd0);
    random_reqs(320);
    set_range(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_reqs(150);
    set_range(32'd500, 32'd100, 32'd1);
    random_reqs(60);
    set_range(32'd0, 32'd4095, 32'd1);
    random_reqs(100);

    drain();
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/lob_pkg.sv
sv/lob_if.sv
sv/lob_ctl.sv
sv/lob_dp.sv
sv/limit_order_book_table_top.sv
tb/tb_top.sv
